FILE: rtl/core/swm_pkg.sv
// Shared types and defaults for the sliding-window median filter.
// No dependencies; used by swm_cell, swm_pick and sliding_window_median.
`default_nettype none

package swm_pkg;

  localparam int unsigned MaxWindowDefault  = 32;
  localparam int unsigned SampleBitsDefault = 16;
  localparam int unsigned CfgBits           = 6;
  localparam logic [CfgBits-1:0] WindowReset = CfgBits'(3);

  // Per-cycle control broadcast to every cell of the sorted chain.
  typedef struct packed {
    logic upd;   // a sample transfer updates the chain this cycle
    logic full;  // the window is full, so the oldest sample leaves
  } cell_ctl_t;

endpackage : swm_pkg

`default_nettype wire

FILE: rtl/core/swm_cell.sv
// One cell of the sorted sample chain: holds a value and its age in the window.
// Depends on swm_pkg for the control struct.
`default_nettype none

module swm_cell #(
  parameter int unsigned MAX_WINDOW  = swm_pkg::MaxWindowDefault,
  parameter int unsigned SAMPLE_BITS = swm_pkg::SampleBitsDefault,
  parameter int unsigned IDX         = 0
) (
  input  wire                                          clk_i,
  input  wire swm_pkg::cell_ctl_t                      ctl_i,
  input  wire logic signed [SAMPLE_BITS-1:0]           sample_i,
  input  wire logic [$clog2(MAX_WINDOW+1)-1:0]         fill_i,
  input  wire logic [$clog2(MAX_WINDOW+1)-1:0]         keep_i,
  input  wire logic [((MAX_WINDOW>1)?$clog2(MAX_WINDOW):1)-1:0] oldest_age_i,
  input  wire logic signed [SAMPLE_BITS-1:0]           left_val_i,
  input  wire logic [((MAX_WINDOW>1)?$clog2(MAX_WINDOW):1)-1:0] left_age_i,
  input  wire logic                                    left_gt_i,
  input  wire logic                                    left_shift_i,
  input  wire logic signed [SAMPLE_BITS-1:0]           right_val_i,
  input  wire logic [((MAX_WINDOW>1)?$clog2(MAX_WINDOW):1)-1:0] right_age_i,
  output logic signed [SAMPLE_BITS-1:0]                val_o,
  output logic [((MAX_WINDOW>1)?$clog2(MAX_WINDOW):1)-1:0] age_o,
  output logic signed [SAMPLE_BITS-1:0]                cmp_val_o,
  output logic [((MAX_WINDOW>1)?$clog2(MAX_WINDOW):1)-1:0] cmp_age_o,
  output logic                                         gt_o,
  output logic                                         shift_o
);

  localparam int unsigned CW = $clog2(MAX_WINDOW+1);
  localparam int unsigned AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam logic [CW-1:0] Idx = CW'(IDX);
  localparam logic [AW-1:0] AgeOne = AW'(1);

  logic signed [SAMPLE_BITS-1:0] val_q, val_d;
  logic [AW-1:0]                 age_q, age_d;
  logic                          evict;
  logic                          kept;
  logic                          take_new;

  // The leaving sample is the oldest one; every cell above it moves down a slot.
  assign evict     = ctl_i.full && (Idx < fill_i) && (age_q == oldest_age_i);
  assign shift_o   = left_shift_i | evict;
  assign cmp_val_o = shift_o ? right_val_i : val_q;
  assign cmp_age_o = shift_o ? right_age_i : age_q;
  assign kept      = Idx < keep_i;
  assign gt_o      = kept && (cmp_val_o > sample_i);
  assign take_new  = gt_o || !kept;

  always_comb begin
    if (left_gt_i) begin
      val_d = left_val_i;
      age_d = left_age_i + AgeOne;
    end else if (take_new) begin
      val_d = sample_i;
      age_d = '0;
    end else begin
      val_d = cmp_val_o;
      age_d = cmp_age_o + AgeOne;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.upd) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  assign val_o = val_q;
  assign age_o = age_q;

endmodule : swm_cell

`default_nettype wire

FILE: rtl/core/swm_pick.sv
// Median selection: picks the middle cell or cells and forms twice the median.
// Depends on swm_pkg for the default parameter values.
`default_nettype none

module swm_pick #(
  parameter int unsigned MAX_WINDOW  = swm_pkg::MaxWindowDefault,
  parameter int unsigned SAMPLE_BITS = swm_pkg::SampleBitsDefault
) (
  input  wire logic signed [SAMPLE_BITS-1:0]   vals_i [MAX_WINDOW],
  input  wire logic [$clog2(MAX_WINDOW+1)-1:0] win_i,
  output logic signed [SAMPLE_BITS:0]          median_o
);

  localparam int unsigned CW = $clog2(MAX_WINDOW+1);
  localparam int unsigned AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic [CW-1:0]                 half;
  logic [AW-1:0]                 hi_idx, lo_idx;
  logic signed [SAMPLE_BITS-1:0] hi_val, lo_val;

  assign half   = win_i >> 1;
  assign hi_idx = half[AW-1:0];
  // An odd window uses the middle value twice.
  assign lo_idx = win_i[0] ? hi_idx : hi_idx - AW'(1);
  assign hi_val = vals_i[hi_idx];
  assign lo_val = vals_i[lo_idx];
  assign median_o = (SAMPLE_BITS+1)'(hi_val) + (SAMPLE_BITS+1)'(lo_val);

endmodule : swm_pick

`default_nettype wire

FILE: rtl/core/sliding_window_median.sv
// Sliding-window median filter: a sorted chain of cells, one per window slot.
// A result reaches m_axis_tdata once the output register frees; meanwhile input stalls.
// Throughput: one sample per cycle unless stalled; every cell updates on the transfer.
// Reset: window size 3, window empty, no result pending.
// Writing the window size empties the window again.
// Depends on swm_pkg, swm_cell and swm_pick.
`default_nettype none

module sliding_window_median #(
  parameter int unsigned MAX_WINDOW  = swm_pkg::MaxWindowDefault,
  parameter int unsigned SAMPLE_BITS = swm_pkg::SampleBitsDefault
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [swm_pkg::CfgBits-1:0]           cfg_wdata_i,   // window_size
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,  // [SB-1:0] sample
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  output logic [((SAMPLE_BITS+8)/8)*8-1:0]           m_axis_tdata   // [SB:0] median_doubled
);

  localparam int unsigned CW = $clog2(MAX_WINDOW+1);
  localparam int unsigned AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned OW = ((SAMPLE_BITS+8)/8)*8;

  logic [swm_pkg::CfgBits-1:0] win_cfg_q;
  logic [CW-1:0]               fill_q, fill_d;
  logic                        pend_q;
  logic                        out_vld_q;
  logic signed [SAMPLE_BITS:0] out_q;

  logic [CW-1:0]               win;
  logic                        full;
  logic                        accept;
  logic                        load;
  logic                        emits;
  logic [CW-1:0]               keep;
  logic [AW-1:0]               oldest_age;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic signed [SAMPLE_BITS:0] median;
  swm_pkg::cell_ctl_t          ctl;

  logic signed [SAMPLE_BITS-1:0] val     [MAX_WINDOW];
  logic [AW-1:0]                 age     [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] cmp_val [MAX_WINDOW];
  logic [AW-1:0]                 cmp_age [MAX_WINDOW];
  logic                          gt      [MAX_WINDOW];
  logic                          shift   [MAX_WINDOW];

  // Size zero acts as one; sizes above the chain length act as the full chain.
  always_comb begin
    if (win_cfg_q == '0) begin
      win = CW'(1);
    end else if (int'(win_cfg_q) > int'(MAX_WINDOW)) begin
      win = CW'(MAX_WINDOW);
    end else begin
      win = CW'(win_cfg_q);
    end
  end

  assign sample     = s_axis_tdata[SAMPLE_BITS-1:0];
  assign full       = (fill_q == win);
  assign keep       = full ? fill_q - CW'(1) : fill_q;
  assign oldest_age = AW'(win - CW'(1));
  assign emits      = full || ((fill_q + CW'(1)) == win);

  assign load          = pend_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !pend_q || load;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign ctl.upd  = accept;
  assign ctl.full = full;

  assign fill_d = full ? fill_q : fill_q + CW'(1);

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] left_val, right_val;
    logic [AW-1:0]                 left_age, right_age;
    logic                          left_gt, left_shift;

    if (i == 0) begin : g_first
      assign left_val   = '0;
      assign left_age   = '0;
      assign left_gt    = 1'b0;
      assign left_shift = 1'b0;
    end else begin : g_inner
      assign left_val   = cmp_val[i-1];
      assign left_age   = cmp_age[i-1];
      assign left_gt    = gt[i-1];
      assign left_shift = shift[i-1];
    end

    if (i == MAX_WINDOW-1) begin : g_last
      assign right_val = val[i];
      assign right_age = age[i];
    end else begin : g_next
      assign right_val = val[i+1];
      assign right_age = age[i+1];
    end

    swm_cell #(
      .MAX_WINDOW (MAX_WINDOW),
      .SAMPLE_BITS(SAMPLE_BITS),
      .IDX        (i)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .sample_i    (sample),
      .fill_i      (fill_q),
      .keep_i      (keep),
      .oldest_age_i(oldest_age),
      .left_val_i  (left_val),
      .left_age_i  (left_age),
      .left_gt_i   (left_gt),
      .left_shift_i(left_shift),
      .right_val_i (right_val),
      .right_age_i (right_age),
      .val_o       (val[i]),
      .age_o       (age[i]),
      .cmp_val_o   (cmp_val[i]),
      .cmp_age_o   (cmp_age[i]),
      .gt_o        (gt[i]),
      .shift_o     (shift[i])
    );
  end

  swm_pick #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_pick (
    .vals_i  (val),
    .win_i   (win),
    .median_o(median)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cfg_q <= swm_pkg::WindowReset;
      fill_q    <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        win_cfg_q <= cfg_wdata_i;
        fill_q    <= '0;
      end else if (accept) begin
        fill_q <= fill_d;
      end

      if (accept) begin
        pend_q <= emits;
      end else if (load) begin
        pend_q <= 1'b0;
      end

      if (load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // The chain already holds the updated window when the result is formed.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= median;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OW'($unsigned(out_q));

endmodule : sliding_window_median

`default_nettype wire

FILE: verif/sliding_window_median_tb.sv
// Self-checking testbench for the sliding-window median filter.
// Depends on swm_pkg and sliding_window_median; a scoreboard class predicts each median.
`default_nettype none

module sliding_window_median_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SampleBits = swm_pkg::SampleBitsDefault;
  localparam int unsigned MaxWindow  = swm_pkg::MaxWindowDefault;
  localparam int unsigned InBytesW   = ((SampleBits + 7) / 8) * 8;
  localparam int unsigned OutBytesW  = ((SampleBits + 8) / 8) * 8;
  localparam int unsigned SettleCycles = 4;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic signed [SampleBits:0]   median_t;
  typedef logic [swm_pkg::CfgBits-1:0]  window_t;

  // Keeps its own copy of the window in arrival and sorted order and queues
  // twice the median for every transfer that leaves the window full.
  class median_scoreboard;
    window_t     window_reg;
    sample_t     arrival[MaxWindow];
    sample_t     ordered[MaxWindow];
    int unsigned fill;
    int unsigned oldest;
    median_t     median_q[$];
    int          errors;

    function new();
      window_reg = swm_pkg::WindowReset;
      fill       = 0;
      oldest     = 0;
      errors     = 0;
    endfunction

    function void set_window(window_t v);
      window_reg = v;
      fill       = 0;
      oldest     = 0;
    endfunction

    function int unsigned pending();
      return median_q.size();
    endfunction

    task report(string msg);
      $display("[swm_tb] mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void note_sample(sample_t s);
      int unsigned w;
      int unsigned slot;
      int unsigned n;
      int unsigned i;
      median_t     lo;
      median_t     hi;
      // A zero window acts as one, anything above the maximum as the maximum.
      if (window_reg == 0) w = 1;
      else if (window_reg > MaxWindow) w = MaxWindow;
      else w = window_reg;
      if (fill >= w) begin
        slot = oldest % w;
        // Drop the first sorted entry equal to the evicted sample.
        i = 0;
        while (i < w && ordered[i] != arrival[slot]) i++;
        for (; i + 1 < w; i++) ordered[i] = ordered[i + 1];
        n = w - 1;
      end else begin
        slot = fill;
        n    = fill;
      end
      i = n;
      while (i > 0 && ordered[i - 1] > s) begin
        ordered[i] = ordered[i - 1];
        i--;
      end
      ordered[i]    = s;
      arrival[slot] = s;
      if (fill >= w) oldest = (slot + 1 >= w) ? 0 : slot + 1;
      else fill++;
      if (fill < w) return;
      if (w % 2 == 1) begin
        lo = ordered[w / 2];
        hi = ordered[w / 2];
      end else begin
        lo = ordered[w / 2 - 1];
        hi = ordered[w / 2];
      end
      median_q.push_back(lo + hi);
    endfunction

    task check_result(logic [OutBytesW-1:0] data);
      median_t got;
      median_t want;
      got = data[SampleBits:0];
      if (median_q.size() == 0) begin
        report($sformatf("median %0d with nothing expected", got));
      end else begin
        want = median_q.pop_front();
        if (got !== want) report($sformatf("median %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  window_t              cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InBytesW-1:0]  s_axis_tdata;   // [15:0] sample
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutBytesW-1:0] m_axis_tdata;   // [16:0] median_doubled

  median_scoreboard sb = new();
  bit               gaps_on = 1'b1;
  int               hold_request = 0;
  int unsigned      sent = 0;

  sliding_window_median dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("[sliding_window_median] ERROR");
    $finish;
  end

  // Result side: checks every transfer, then picks tready for the next cycle.
  initial begin
    int hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(99) < 9) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Spread over the full range, with clusters that give many equal samples.
  function automatic sample_t next_sample();
    int unsigned pick;
    sample_t     corners[7];
    corners = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32766, 16'sd32767};
    pick = $urandom_range(99);
    if (pick < 40) return sample_t'($urandom_range(16'hffff));
    if (pick < 65) return sample_t'($signed($urandom_range(8)) - 4);
    if (pick < 80) return corners[$urandom_range(6)];
    return sample_t'($signed($urandom_range(400)) - 200 + 1000);
  endfunction

  task automatic send_sample(input sample_t s);
    while (gaps_on && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InBytesW'($unsigned(s));
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(s);
    sent++;
  endtask

  // Stops offering samples until every queued median has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_window(input window_t v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.set_window(v);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_sample(next_sample());
  endtask

  initial begin
    window_t     sizes[8];
    sample_t     directed[22];
    int unsigned wait_left;
    sizes    = '{6'd0, 6'd1, 6'd2, 6'd32, 6'd63, 6'd33, 6'd31, 6'd4};
    directed = '{16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768,
                 -16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1, 16'sd5, 16'sd5,
                 16'sd5, -16'sd7, 16'sd5, 16'sd5, 16'sd100, -16'sd100, 16'sd0,
                 16'sd32767, -16'sd32768, 16'sd0};
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset window of three: extremes, repeats and mixed signs.
    foreach (directed[i]) send_sample(directed[i]);
    // A zero window behaves as one; each sample is its own median.
    write_window(6'd0);
    foreach (directed[i]) if (i < 4) send_sample(directed[i]);
    // Two equal extremes give the largest and smallest even-window sums.
    write_window(6'd2);
    send_sample(16'sd32767);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(-16'sd32768);
    // Rewrite while partly filled: the window must start over empty.
    write_window(6'd5);
    send_sample(16'sd9);
    send_sample(-16'sd9);
    write_window(6'd5);

    // Fixed settings first, the extremes among them.
    foreach (sizes[i]) begin
      write_window(sizes[i]);
      if (i == 2) gaps_on = 1'b0;
      if (sizes[i] == 6'd32) begin
        run_phase(50);
        hold_request = 400;
        run_phase(100);
        wait_drained();
        run_phase(50);
      end else begin
        run_phase($urandom_range(40, 120));
      end
      gaps_on = 1'b1;
    end

    while (sent < 1500) begin
      write_window(window_t'($urandom_range(63)));
      if ($urandom_range(3) == 0) run_phase($urandom_range(1, 40));
      else run_phase($urandom_range(40, 160));
    end

    s_axis_tvalid <= 1'b0;
    wait_left = 2000;
    while (sb.pending() != 0 && wait_left > 0) begin
      @(posedge clk_i);
      wait_left--;
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d medians never arrived", sb.pending()));

    if (sb.errors == 0) begin
      $display("[sliding_window_median] OK");
    end else begin
      $display("[sliding_window_median] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
